>>> hdl/ppts_pkg.sv
// ----------------------------------------------------------------------------
// ppts_pkg
// types and fixed codes shared by the priority task scheduler
// ----------------------------------------------------------------------------
package ppts_pkg;

  localparam int ID_W     = 8;
  localparam int PRIO_W   = 2;
  localparam int DUR_W    = 16;
  localparam int NUM_PRIO = 3;

  // command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_REJECTED = 3'd1,
    ST_IDLE     = 3'd2,
    ST_RAN      = 3'd3,
    ST_DONE     = 3'd4
  } status_t;

  // queue entry: priority is implied by the queue it sits in
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [DUR_W-1:0] rem;
  } queue_word_t;

  // stack entry: a preempted task with its priority
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [DUR_W-1:0]  rem;
  } stack_word_t;

endpackage

>>> hdl/preemptive_priority_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// preemptive_priority_task_scheduler_core
// fixed-priority preemptive scheduler, three fifo queues and a preemption stack
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. An add word uses only
// the accept cycle: the task is written to its queue ram and the result
// strobes on done in the next cycle, with busy staying low. A tick word uses
// the accept cycle, which decides on preemption and issues the registered
// read of the queue ram or the stack ram, then S_LOAD, which loads and runs
// the processor slot; busy is high in S_LOAD and done strobes in the cycle
// after it, when the next word may already be taken. done is high for exactly
// one cycle per word and the result ports hold only during that cycle: the
// receiver cannot stall the block, so it must capture each result as it comes.
// Both rams hold undefined contents after reset and need no clearing pass.
module preemptive_priority_task_scheduler_core #(
  parameter int QUEUE_DEPTH = 64,
  parameter int STACK_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command,
  input  logic [ppts_pkg::ID_W-1:0]   task_id,
  input  logic [ppts_pkg::PRIO_W-1:0] task_priority,
  input  logic [ppts_pkg::DUR_W-1:0]  task_duration,
  output logic                        done,
  output logic [2:0]                  status,
  output logic [ppts_pkg::ID_W-1:0]   running_id,
  output logic [ppts_pkg::PRIO_W-1:0] running_priority,
  output logic                        preempted,
  output logic [ppts_pkg::ID_W-1:0]   preempted_id,
  output logic                        stack_full_flag,
  output logic [15:0]                 tick_number
);

  // index, count and address widths
  localparam int QIW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int QAW = $clog2(ppts_pkg::NUM_PRIO * QUEUE_DEPTH);
  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int SLW = $clog2(STACK_DEPTH + 1);
  localparam int QWW = $bits(ppts_pkg::queue_word_t);
  localparam int SWW = $bits(ppts_pkg::stack_word_t);

  typedef enum logic {
    S_IDLE,
    S_LOAD
  } state_t;

  state_t state;

  // queue pointers, one per priority
  logic [QIW-1:0] heads  [ppts_pkg::NUM_PRIO];
  logic [QIW-1:0] tails  [ppts_pkg::NUM_PRIO];
  logic [QCW-1:0] counts [ppts_pkg::NUM_PRIO];
  logic [SLW-1:0] stack_level;

  // processor slot
  logic                        slot_valid;
  logic [ppts_pkg::ID_W-1:0]   slot_id;
  logic [ppts_pkg::PRIO_W-1:0] slot_prio;
  logic [ppts_pkg::DUR_W-1:0]  slot_rem;

  logic [15:0] tick_counter;

  // decisions carried from the first tick cycle into the load cycle
  logic                        load_q;
  logic                        load_s;
  logic [ppts_pkg::PRIO_W-1:0] bp_held;
  logic                        pre_held;
  logic [ppts_pkg::ID_W-1:0]   pre_id_held;
  logic                        full_held;
  logic [15:0]                 tnum_held;

  ppts_pkg::status_t status_r;

  // ram ports
  logic        q_wr_en, q_rd_en, s_wr_en, s_rd_en;
  logic [QAW-1:0] q_wr_addr, q_rd_addr;
  logic [SIW-1:0] s_wr_addr, s_rd_addr;
  ppts_pkg::queue_word_t q_wr_data, q_rd_data;
  ppts_pkg::stack_word_t s_wr_data, s_rd_data;

  // base of each priority's ring in the shared queue ram
  function automatic logic [QAW-1:0] qbase(input logic [ppts_pkg::PRIO_W-1:0] p);
    logic [QAW-1:0] b;
    case (p)
      2'd1:    b = QAW'(QUEUE_DEPTH);
      2'd2:    b = QAW'(2 * QUEUE_DEPTH);
      default: b = '0;
    endcase
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // accept-cycle decisions
  // ---------------------------------------------------------------------------
  logic                        accept;
  logic                        is_tick;
  logic                        add_ok;
  logic [QCW-1:0]              add_count;
  logic [QIW-1:0]              add_tail;
  logic                        bp_valid;
  logic [ppts_pkg::PRIO_W-1:0] bp;
  logic [QIW-1:0]              bp_head;
  logic                        need_pre;
  logic                        push;
  logic                        slot_free;
  logic                        take_q;
  logic                        take_s;

  always_comb begin
    accept  = start && (state == S_IDLE);
    is_tick = (command == ppts_pkg::CMD_TICK);

    // add: pick the target queue, priority three has no queue
    case (task_priority)
      2'd0:    begin add_count = counts[0]; add_tail = tails[0]; end
      2'd1:    begin add_count = counts[1]; add_tail = tails[1]; end
      2'd2:    begin add_count = counts[2]; add_tail = tails[2]; end
      default: begin add_count = '0;        add_tail = '0;       end
    endcase
    add_ok = (task_priority != 2'd3) && (add_count < QCW'(QUEUE_DEPTH));

    // best non-empty queue, lowest index wins
    bp_valid = 1'b1;
    if (counts[0] != '0) begin
      bp = 2'd0;
      bp_head = heads[0];
    end else if (counts[1] != '0) begin
      bp = 2'd1;
      bp_head = heads[1];
    end else if (counts[2] != '0) begin
      bp = 2'd2;
      bp_head = heads[2];
    end else begin
      bp = 2'd3;
      bp_head = '0;
      bp_valid = 1'b0;
    end

    // preemption only for a strictly better queued task
    need_pre  = slot_valid && bp_valid && (bp < slot_prio);
    push      = need_pre && (stack_level < SLW'(STACK_DEPTH));
    slot_free = !slot_valid || push;
    take_q    = slot_free && bp_valid;
    take_s    = slot_free && !bp_valid && (stack_level != '0);

    q_wr_en   = accept && !is_tick && add_ok;
    q_wr_addr = qbase(task_priority) + QAW'(add_tail);
    q_wr_data = '{id: task_id, rem: task_duration};
    q_rd_en   = accept && is_tick && take_q;
    q_rd_addr = qbase(bp) + QAW'(bp_head);

    s_wr_en   = accept && is_tick && push;
    s_wr_addr = stack_level[SIW-1:0];
    s_wr_data = '{id: slot_id, prio: slot_prio, rem: slot_rem};
    s_rd_en   = accept && is_tick && take_s;
    s_rd_addr = SIW'(stack_level - SLW'(1));
  end

  // ---------------------------------------------------------------------------
  // load-cycle view of the slot: ram data arrives here
  // ---------------------------------------------------------------------------
  logic                        eff_valid;
  logic [ppts_pkg::ID_W-1:0]   eff_id;
  logic [ppts_pkg::PRIO_W-1:0] eff_prio;
  logic [ppts_pkg::DUR_W-1:0]  eff_rem;
  logic                        eff_last;

  always_comb begin
    eff_valid = slot_valid || load_q || load_s;
    if (load_q) begin
      eff_id   = q_rd_data.id;
      eff_prio = bp_held;
      eff_rem  = q_rd_data.rem;
    end else if (load_s) begin
      eff_id   = s_rd_data.id;
      eff_prio = s_rd_data.prio;
      eff_rem  = s_rd_data.rem;
    end else begin
      eff_id   = slot_id;
      eff_prio = slot_prio;
      eff_rem  = slot_rem;
    end
    // zero duration acts as one
    eff_last = (eff_rem <= ppts_pkg::DUR_W'(1));
  end

  // ---------------------------------------------------------------------------
  // state, pointers, slot and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      stack_level  <= '0;
      slot_valid   <= 1'b0;
      slot_id      <= '0;
      slot_prio    <= '0;
      slot_rem     <= '0;
      tick_counter <= '0;
      load_q       <= 1'b0;
      load_s       <= 1'b0;
      for (int i = 0; i < ppts_pkg::NUM_PRIO; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          // only an add word answers straight away
          done <= accept && !is_tick;
          if (accept && !is_tick) begin
            // add word: queue or reject, result next cycle
            if (add_ok) begin
              tails[task_priority[1:0]] <= (add_tail == QIW'(QUEUE_DEPTH - 1)) ?
                                           '0 : add_tail + QIW'(1);
              counts[task_priority[1:0]] <= add_count + QCW'(1);
              status_r <= ppts_pkg::ST_QUEUED;
            end else begin
              status_r <= ppts_pkg::ST_REJECTED;
            end
            running_id       <= '0;
            running_priority <= '0;
            preempted        <= 1'b0;
            preempted_id     <= '0;
            stack_full_flag  <= 1'b0;
            tick_number      <= tick_counter;
          end else if (accept) begin
            // tick word, first cycle
            state        <= S_LOAD;
            load_q       <= take_q;
            load_s       <= take_s;
            bp_held      <= bp;
            pre_held     <= push;
            pre_id_held  <= push ? slot_id : '0;
            full_held    <= need_pre && !push;
            tnum_held    <= tick_counter;
            tick_counter <= tick_counter + 16'd1;
            if (push) begin
              slot_valid  <= 1'b0;
              stack_level <= stack_level + SLW'(1);
            end
            if (take_q) begin
              heads[bp[1:0]]  <= (bp_head == QIW'(QUEUE_DEPTH - 1)) ?
                                 '0 : bp_head + QIW'(1);
              counts[bp[1:0]] <= counts[bp[1:0]] - QCW'(1);
            end
            if (take_s) begin
              stack_level <= stack_level - SLW'(1);
            end
          end
        end
        S_LOAD: begin
          // run the loaded task for one tick
          state  <= S_IDLE;
          load_q <= 1'b0;
          load_s <= 1'b0;
          if (eff_valid) begin
            running_id       <= eff_id;
            running_priority <= eff_prio;
            if (eff_last) begin
              status_r   <= ppts_pkg::ST_DONE;
              slot_valid <= 1'b0;
              slot_id    <= '0;
              slot_prio  <= '0;
              slot_rem   <= '0;
            end else begin
              status_r   <= ppts_pkg::ST_RAN;
              slot_valid <= 1'b1;
              slot_id    <= eff_id;
              slot_prio  <= eff_prio;
              slot_rem   <= eff_rem - ppts_pkg::DUR_W'(1);
            end
          end else begin
            status_r         <= ppts_pkg::ST_IDLE;
            running_id       <= '0;
            running_priority <= '0;
          end
          preempted       <= pre_held;
          preempted_id    <= pre_id_held;
          stack_full_flag <= full_held;
          tick_number     <= tnum_held;
          done            <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

  assign busy   = (state != S_IDLE);
  assign status = status_r;

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  // all three rings share one ram, priority p at offset p * QUEUE_DEPTH
  ppts_ram #(
    .WIDTH (QWW),
    .DEPTH (ppts_pkg::NUM_PRIO * QUEUE_DEPTH)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_wr_en),
    .wr_addr (q_wr_addr),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_addr (q_rd_addr),
    .rd_data (q_rd_data)
  );

  // preemption stack, level points at the next free entry
  ppts_ram #(
    .WIDTH (SWW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (s_wr_en),
    .wr_addr (s_wr_addr),
    .wr_data (s_wr_data),
    .rd_en   (s_rd_en),
    .rd_addr (s_rd_addr),
    .rd_data (s_rd_data)
  );

endmodule

>>> hdl/ppts_ram.sv
// ----------------------------------------------------------------------------
// ppts_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ppts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
